@@ rtl/assert_macros.svh @@
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

@@ rtl/bmut_pkg.sv @@
`default_nettype none

package bmut_pkg;

    // Default sizes of the source store and the destination range.
    localparam int SRC_MAX_W_DEF = 128;
    localparam int SRC_MAX_H_DEF = 128;
    localparam int DST_MAX_DEF   = 4096;

    // Stream word layout.
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Number formats.
    localparam int SCALE_W  = 24;
    localparam int SAMPLE_W = 16;
    localparam int FRAC_W   = 17;
    localparam logic [FRAC_W-1:0] Q16_ONE = 17'd65536;
    localparam int POS_OFFSET = 65536;

    // Operation codes carried in tuser.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD     = 3'd4;

    // Result codes.
    localparam logic [M_TDATA_W-1:0] MASK_ON  = 8'd255;
    localparam logic [M_TDATA_W-1:0] MASK_OFF = 8'd0;

    // Result queue.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int CNT_W      = 4;

endpackage

`default_nettype wire

@@ rtl/bmut_axis.sv @@
`default_nettype none

module bmut_axis #(
    parameter int PW = 37,
    parameter int IW = 7
) (
    input  wire logic [PW-1:0]              prod,
    input  wire logic [IW-1:0]              last,
    output logic      [IW-1:0]              lo,
    output logic      [IW-1:0]              hi,
    output logic      [bmut_pkg::FRAC_W-1:0] frac,
    output logic      [bmut_pkg::FRAC_W-1:0] comp
);
    import bmut_pkg::*;

    localparam int IXW = PW - 17;

    logic          neg;
    logic [PW-1:0] pos;
    logic [IXW-1:0] i0;
    logic          over;
    logic          at_edge;

    // Source position in Q.17 is (2d+1)*scale - 0.5; negative means left of the source.
    assign neg     = prod < PW'(POS_OFFSET);
    assign pos     = prod - PW'(POS_OFFSET);
    assign i0      = pos[PW-1:17];
    assign over    = i0 > IXW'(last);
    assign at_edge = i0 >= IXW'(last);

    // Clamp both neighbor indexes to the source edges.
    always_comb begin
        if (neg) begin
            lo = '0;
            hi = '0;
        end else begin
            lo = over ? last : i0[IW-1:0];
            hi = at_edge ? last : i0[IW-1:0] + IW'(1);
        end
    end

    // Fraction saturates at one beyond the last sample and is truncated to Q.16.
    always_comb begin
        if (neg) begin
            frac = '0;
        end else if (over) begin
            frac = Q16_ONE;
        end else begin
            frac = {1'b0, pos[16:1]};
        end
    end

    assign comp = Q16_ONE - frac;

endmodule

`default_nettype wire

@@ rtl/bmut_store.sv @@
`default_nettype none

module bmut_store #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14
) (
    input  wire logic                           aclk,
    input  wire logic                           we,
    input  wire logic [AW-1:0]                  waddr,
    input  wire logic [bmut_pkg::SAMPLE_W-1:0]  wdata,
    input  wire logic                           re,
    input  wire logic [AW-1:0]                  raddr0,
    input  wire logic [AW-1:0]                  raddr1,
    output logic      [bmut_pkg::SAMPLE_W-1:0]  rdata0_reg,
    output logic      [bmut_pkg::SAMPLE_W-1:0]  rdata1_reg
);
    import bmut_pkg::*;

    logic [SAMPLE_W-1:0] mem [DEPTH];

    // One write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Two registered read ports.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata0_reg <= mem[raddr0];
            rdata1_reg <= mem[raddr1];
        end
    end

endmodule

`default_nettype wire

@@ rtl/bilinear_mask_upsample_threshold_unit.sv @@
// A pixel's result goes through stages 1 to 4b, the read return, v1, v2 and the result queue
// to m_tvalid. Throughput: one load word per cycle while s_tready is high; the input is held
// after a pixel word, as its four neighbor reads share the two read ports of the store.
// Reset (aresetn low, synchronous) empties the pipeline and the result queue and sets the
// registers to width 1, height 1, unit scales and threshold 0; the store keeps its contents.
`default_nettype none
`include "assert_macros.svh"

module bilinear_mask_upsample_threshold_unit #(
    parameter int SRC_MAX_W = bmut_pkg::SRC_MAX_W_DEF,
    parameter int SRC_MAX_H = bmut_pkg::SRC_MAX_H_DEF,
    parameter int DST_MAX   = bmut_pkg::DST_MAX_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // Input words.
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // [13:0] sample_index, [29:14] sample_value, [41:30] dest_x, [53:42] dest_y, [55:54] zero
    input  wire logic [bmut_pkg::S_TDATA_W-1:0]   s_tdata,
    // [0] operation
    input  wire logic [0:0]                       s_tuser,
    // Result words.
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [7:0] mask_byte
    output logic      [bmut_pkg::M_TDATA_W-1:0]   m_tdata,
    // Configuration writes.
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [bmut_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bmut_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bmut_pkg::*;

    localparam int DEPTH = SRC_MAX_W * SRC_MAX_H;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WW    = $clog2(SRC_MAX_W + 1);
    localparam int HW    = $clog2(SRC_MAX_H + 1);
    localparam int XW    = (SRC_MAX_W > 1) ? $clog2(SRC_MAX_W) : 1;
    localparam int YW    = (SRC_MAX_H > 1) ? $clog2(SRC_MAX_H) : 1;
    localparam int DW    = $clog2(DST_MAX);
    localparam int CMW   = (DW > 12) ? DW : 12;
    localparam int PW    = DW + 1 + SCALE_W;
    localparam int RW    = 33;
    localparam int VW    = 51;
    localparam logic [32:0] RECIP =
        33'((64'd4294967296 + 64'(DEPTH) - 64'd1) / 64'(DEPTH));
    localparam logic [CNT_W-1:0] FIFO_FULL = CNT_W'(FIFO_DEPTH);

    // ------------------------------------------------------------------
    // Configuration registers, sizes clamped on write.
    // ------------------------------------------------------------------
    logic [WW-1:0]       width_reg;
    logic [HW-1:0]       height_reg;
    logic [SCALE_W-1:0]  scale_x_reg;
    logic [SCALE_W-1:0]  scale_y_reg;
    logic signed [15:0]  thr_reg;
    logic [WW-1:0]       width_clamp;
    logic [HW-1:0]       height_clamp;

    assign cfg_ready = 1'b1;

    always_comb begin
        if (cfg_data[7:0] == 8'd0) begin
            width_clamp = WW'(1);
        end else if (32'(cfg_data[7:0]) > 32'(SRC_MAX_W)) begin
            width_clamp = WW'(SRC_MAX_W);
        end else begin
            width_clamp = WW'(cfg_data[7:0]);
        end
        if (cfg_data[7:0] == 8'd0) begin
            height_clamp = HW'(1);
        end else if (32'(cfg_data[7:0]) > 32'(SRC_MAX_H)) begin
            height_clamp = HW'(SRC_MAX_H);
        end else begin
            height_clamp = HW'(cfg_data[7:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= WW'(1);
            height_reg  <= HW'(1);
            scale_x_reg <= 24'd65536;
            scale_y_reg <= 24'd65536;
            thr_reg     <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_SOURCE_WIDTH:  width_reg   <= width_clamp;
                REG_SOURCE_HEIGHT: height_reg  <= height_clamp;
                REG_SCALE_X:       scale_x_reg <= cfg_data;
                REG_SCALE_Y:       scale_y_reg <= cfg_data;
                REG_THRESHOLD:     thr_reg     <= $signed(cfg_data[15:0]);
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input handshake: a pixel word blocks the next cycle, and no word is
    // taken unless the result queue has room for every pixel in flight.
    // ------------------------------------------------------------------
    logic             in_acc;
    logic             pix_acc;
    logic             pop;
    logic             gap_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign s_tready = !gap_reg && (cnt_reg < FIFO_FULL);
    assign in_acc   = s_tvalid && s_tready;
    assign pix_acc  = in_acc && (s_tuser[0] == OP_PIXEL);
    assign pop      = m_tvalid && m_tready;

    always_comb begin
        cnt_next = cnt_reg;
        if (pix_acc && !pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (!pix_acc && pop) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            gap_reg <= pix_acc;
            cnt_reg <= cnt_next;
        end
    end

    // Destination coordinates saturate to the last destination column or row.
    logic [DW-1:0] dx_sat;
    logic [DW-1:0] dy_sat;

    assign dx_sat = (CMW'(s_tdata[41:30]) > CMW'(DST_MAX - 1)) ? DW'(DST_MAX - 1)
                                                              : DW'(s_tdata[41:30]);
    assign dy_sat = (CMW'(s_tdata[53:42]) > CMW'(DST_MAX - 1)) ? DW'(DST_MAX - 1)
                                                              : DW'(s_tdata[53:42]);

    // ------------------------------------------------------------------
    // Stage 1: source position products and load index reciprocal product.
    // ------------------------------------------------------------------
    logic                s1_valid_reg;
    logic                s1_op_reg;
    logic [13:0]         s1_idx_reg;
    logic [SAMPLE_W-1:0] s1_val_reg;
    logic [DW-1:0]       s1_dx_reg;
    logic [DW-1:0]       s1_dy_reg;
    logic [PW-1:0]       prod_x;
    logic [PW-1:0]       prod_y;
    logic [46:0]         qmul;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_acc;
        end
    end

    always_ff @(posedge aclk) begin
        s1_op_reg  <= s_tuser[0];
        s1_idx_reg <= s_tdata[13:0];
        s1_val_reg <= s_tdata[29:14];
        s1_dx_reg  <= dx_sat;
        s1_dy_reg  <= dy_sat;
    end

    assign prod_x = PW'({s1_dx_reg, 1'b1}) * PW'(scale_x_reg);
    assign prod_y = PW'({s1_dy_reg, 1'b1}) * PW'(scale_y_reg);
    assign qmul   = 47'(s1_idx_reg) * 47'(RECIP);

    // ------------------------------------------------------------------
    // Stage 2: neighbor indexes and fractions; load index wraps to the store.
    // ------------------------------------------------------------------
    logic                s2_valid_reg;
    logic                s2_op_reg;
    logic [13:0]         s2_idx_reg;
    logic [13:0]         s2_q_reg;
    logic [SAMPLE_W-1:0] s2_val_reg;
    logic [PW-1:0]       s2_px_reg;
    logic [PW-1:0]       s2_py_reg;
    logic [XW-1:0]       ax_lo, ax_hi;
    logic [YW-1:0]       ay_lo, ay_hi;
    logic [FRAC_W-1:0]   ax_f, ax_g, ay_f, ay_g;
    logic [31:0]         qd;
    logic [31:0]         rem_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s2_op_reg  <= s1_op_reg;
        s2_idx_reg <= s1_idx_reg;
        s2_q_reg   <= qmul[45:32];
        s2_val_reg <= s1_val_reg;
        s2_px_reg  <= prod_x;
        s2_py_reg  <= prod_y;
    end

    bmut_axis #(.PW(PW), .IW(XW)) u_axis_x (
        .prod (s2_px_reg),
        .last (XW'(width_reg - WW'(1))),
        .lo   (ax_lo),
        .hi   (ax_hi),
        .frac (ax_f),
        .comp (ax_g)
    );

    bmut_axis #(.PW(PW), .IW(YW)) u_axis_y (
        .prod (s2_py_reg),
        .last (YW'(height_reg - HW'(1))),
        .lo   (ay_lo),
        .hi   (ay_hi),
        .frac (ay_f),
        .comp (ay_g)
    );

    assign qd       = 32'(s2_q_reg) * 32'(DEPTH);
    assign rem_full = 32'(s2_idx_reg) - qd;

    // ------------------------------------------------------------------
    // Stage 3: row base addresses.
    // ------------------------------------------------------------------
    logic                s3_valid_reg;
    logic                s3_op_reg;
    logic [SAMPLE_W-1:0] s3_val_reg;
    logic [AW-1:0]       s3_waddr_reg;
    logic [XW-1:0]       s3_x0_reg, s3_x1_reg;
    logic [YW-1:0]       s3_y0_reg, s3_y1_reg;
    logic [FRAC_W-1:0]   s3_fx_reg, s3_gx_reg, s3_fy_reg, s3_gy_reg;
    logic [YW+WW-1:0]    row0_full;
    logic [YW+WW-1:0]    row1_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s3_op_reg    <= s2_op_reg;
        s3_val_reg   <= s2_val_reg;
        s3_waddr_reg <= AW'(rem_full);
        s3_x0_reg    <= ax_lo;
        s3_x1_reg    <= ax_hi;
        s3_y0_reg    <= ay_lo;
        s3_y1_reg    <= ay_hi;
        s3_fx_reg    <= ax_f;
        s3_gx_reg    <= ax_g;
        s3_fy_reg    <= ay_f;
        s3_gy_reg    <= ay_g;
    end

    assign row0_full = (YW+WW)'(s3_y0_reg) * (YW+WW)'(width_reg);
    assign row1_full = (YW+WW)'(s3_y1_reg) * (YW+WW)'(width_reg);

    // ------------------------------------------------------------------
    // Stage 4a: load writes, pixel reads its upper row pair.
    // Stage 4b: pixel reads its lower row pair.
    // ------------------------------------------------------------------
    logic                s4a_valid_reg;
    logic                s4a_op_reg;
    logic [SAMPLE_W-1:0] s4a_val_reg;
    logic [AW-1:0]       s4a_waddr_reg;
    logic [AW-1:0]       s4a_row0_reg, s4a_row1_reg;
    logic [XW-1:0]       s4a_x0_reg, s4a_x1_reg;
    logic [FRAC_W-1:0]   s4a_fx_reg, s4a_gx_reg, s4a_fy_reg, s4a_gy_reg;
    logic                s4a_pix;
    logic                s4a_load;

    logic                s4b_valid_reg;
    logic [AW-1:0]       s4b_row1_reg;
    logic [XW-1:0]       s4b_x0_reg, s4b_x1_reg;
    logic [FRAC_W-1:0]   s4b_fx_reg, s4b_gx_reg, s4b_fy_reg, s4b_gy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4a_valid_reg <= 1'b0;
            s4b_valid_reg <= 1'b0;
        end else begin
            s4a_valid_reg <= s3_valid_reg;
            s4b_valid_reg <= s4a_pix;
        end
    end

    always_ff @(posedge aclk) begin
        s4a_op_reg    <= s3_op_reg;
        s4a_val_reg   <= s3_val_reg;
        s4a_waddr_reg <= s3_waddr_reg;
        s4a_row0_reg  <= AW'(row0_full);
        s4a_row1_reg  <= AW'(row1_full);
        s4a_x0_reg    <= s3_x0_reg;
        s4a_x1_reg    <= s3_x1_reg;
        s4a_fx_reg    <= s3_fx_reg;
        s4a_gx_reg    <= s3_gx_reg;
        s4a_fy_reg    <= s3_fy_reg;
        s4a_gy_reg    <= s3_gy_reg;
        s4b_row1_reg  <= s4a_row1_reg;
        s4b_x0_reg    <= s4a_x0_reg;
        s4b_x1_reg    <= s4a_x1_reg;
        s4b_fx_reg    <= s4a_fx_reg;
        s4b_gx_reg    <= s4a_gx_reg;
        s4b_fy_reg    <= s4a_fy_reg;
        s4b_gy_reg    <= s4a_gy_reg;
    end

    assign s4a_pix  = s4a_valid_reg && (s4a_op_reg == OP_PIXEL);
    assign s4a_load = s4a_valid_reg && (s4a_op_reg == OP_LOAD);

    // The slot behind a pixel is always empty, so 4a and 4b never read together.
    logic                mem_re;
    logic [AW-1:0]       mem_raddr0, mem_raddr1;
    logic [SAMPLE_W-1:0] mem_rdata0, mem_rdata1;

    assign mem_re     = s4a_pix || s4b_valid_reg;
    assign mem_raddr0 = s4a_pix ? (s4a_row0_reg + AW'(s4a_x0_reg))
                                : (s4b_row1_reg + AW'(s4b_x0_reg));
    assign mem_raddr1 = s4a_pix ? (s4a_row0_reg + AW'(s4a_x1_reg))
                                : (s4b_row1_reg + AW'(s4b_x1_reg));

    bmut_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
        .aclk       (aclk),
        .we         (s4a_load),
        .waddr      (s4a_waddr_reg),
        .wdata      (s4a_val_reg),
        .re         (mem_re),
        .raddr0     (mem_raddr0),
        .raddr1     (mem_raddr1),
        .rdata0_reg (mem_rdata0),
        .rdata1_reg (mem_rdata1)
    );

    // ------------------------------------------------------------------
    // Read return: horizontal blend of each row pair.
    // ------------------------------------------------------------------
    logic                    rd_valid_reg;
    logic                    rd_row1_reg;
    logic [FRAC_W-1:0]       rd_fx_reg, rd_gx_reg, rd_fy_reg, rd_gy_reg;
    logic signed [RW-1:0]    lp0, lp1, row_blend;
    logic signed [RW-1:0]    r0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= mem_re;
        end
    end

    always_ff @(posedge aclk) begin
        rd_row1_reg <= !s4a_pix;
        rd_fx_reg   <= s4a_pix ? s4a_fx_reg : s4b_fx_reg;
        rd_gx_reg   <= s4a_pix ? s4a_gx_reg : s4b_gx_reg;
        rd_fy_reg   <= s4a_pix ? s4a_fy_reg : s4b_fy_reg;
        rd_gy_reg   <= s4a_pix ? s4a_gy_reg : s4b_gy_reg;
    end

    assign lp0       = RW'($signed(mem_rdata0)) * RW'($signed({1'b0, rd_gx_reg}));
    assign lp1       = RW'($signed(mem_rdata1)) * RW'($signed({1'b0, rd_fx_reg}));
    assign row_blend = lp0 + lp1;

    always_ff @(posedge aclk) begin
        if (rd_valid_reg && !rd_row1_reg) begin
            r0_reg <= row_blend;
        end
    end

    // ------------------------------------------------------------------
    // Vertical blend: both row results, then the two weighted products.
    // ------------------------------------------------------------------
    logic                    v1_valid_reg;
    logic signed [RW-1:0]    v1_r0_reg, v1_r1_reg;
    logic [FRAC_W-1:0]       v1_fy_reg, v1_gy_reg;
    logic                    v2_valid_reg;
    logic signed [VW-1:0]    v2_p0_reg, v2_p1_reg;
    logic signed [VW-1:0]    blend;
    logic signed [VW-1:0]    thr_ext;
    logic                    hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_valid_reg <= 1'b0;
            v2_valid_reg <= 1'b0;
        end else begin
            v1_valid_reg <= rd_valid_reg && rd_row1_reg;
            v2_valid_reg <= v1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        v1_r0_reg <= r0_reg;
        v1_r1_reg <= row_blend;
        v1_fy_reg <= rd_fy_reg;
        v1_gy_reg <= rd_gy_reg;
        v2_p0_reg <= VW'(v1_r0_reg) * VW'($signed({1'b0, v1_gy_reg}));
        v2_p1_reg <= VW'(v1_r1_reg) * VW'($signed({1'b0, v1_fy_reg}));
    end

    // Threshold scaled to the blend's Q.32 weight sum.
    assign blend   = v2_p0_reg + v2_p1_reg;
    assign thr_ext = $signed({{3{thr_reg[15]}}, thr_reg, 32'd0});
    assign hit     = blend > thr_ext;

    // ------------------------------------------------------------------
    // Result queue: holds one decision bit per pixel.
    // ------------------------------------------------------------------
    logic                   push;
    logic                   fifo_bits_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]     wptr_reg, rptr_reg;
    logic [FIFO_AW-1:0]     wptr_next, rptr_next;
    logic [CNT_W-1:0]       fcnt_reg, fcnt_next;

    assign push = v2_valid_reg;

    always_comb begin
        wptr_next = push ? wptr_reg + FIFO_AW'(1) : wptr_reg;
        rptr_next = pop ? rptr_reg + FIFO_AW'(1) : rptr_reg;
        fcnt_next = fcnt_reg;
        if (push && !pop) begin
            fcnt_next = fcnt_reg + CNT_W'(1);
        end else if (!push && pop) begin
            fcnt_next = fcnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fcnt_reg <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fcnt_reg <= fcnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_bits_reg[wptr_reg] <= hit;
        end
    end

    assign m_tvalid = (fcnt_reg != '0);
    assign m_tdata  = fifo_bits_reg[rptr_reg] ? MASK_ON : MASK_OFF;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `ASSERT_IMP(a_single_reader, aclk, aresetn, s4a_pix, !s4b_valid_reg)
    `ASSERT_NXT(a_pixel_gap, aclk, aresetn, pix_acc, !s_tready)
    `ASSERT_IMP(a_credit_cover, aclk, aresetn, 1'b1, fcnt_reg <= cnt_reg)
    `ASSERT_IMP(a_queue_room, aclk, aresetn, push, fcnt_reg < FIFO_FULL)

endmodule

`default_nettype wire

@@ test/bmut_mask_checker.sv @@
`timescale 1ns / 1ps

// Watches the input, result and configuration channels of the mask upsampler,
// keeps its own copy of the sample store and registers, predicts one mask byte
// per pixel word and compares each result word with the oldest prediction.
module bmut_mask_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // [13:0] sample_index, [29:14] sample_value, [41:30] dest_x, [53:42] dest_y
    input  logic [bmut_pkg::S_TDATA_W-1:0]  s_tdata,
    // [0] operation
    input  logic [0:0]                      s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] mask_byte
    input  logic [bmut_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [bmut_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bmut_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              mismatches,
    output int                              outstanding
);
    import bmut_pkg::*;

    localparam int     STORE_DEPTH = SRC_MAX_W_DEF * SRC_MAX_H_DEF;
    localparam longint ONE_Q17     = 131072;

    logic signed [SAMPLE_W-1:0] logit_mem [STORE_DEPTH];
    logic        [7:0]          width_reg;
    logic        [7:0]          height_reg;
    logic        [SCALE_W-1:0]  scale_x_reg;
    logic        [SCALE_W-1:0]  scale_y_reg;
    logic signed [15:0]         thr_reg;
    logic        [M_TDATA_W-1:0] mask_q [$];
    logic        [M_TDATA_W-1:0] want;

    // A zero size acts as one; an oversize saturates to the store's maximum.
    function automatic longint extent_of(input logic [7:0] v, input int max);
        if (v == 0) return 1;
        return (v > max) ? max : v;
    endfunction

    function automatic longint logit_at(input longint idx);
        return longint'(logit_mem[idx % STORE_DEPTH]);
    endfunction

    // One axis of the half-pixel-center mapping, positions kept exactly in Q.17.
    function automatic void map_axis(input longint d, input longint scale,
                                     input longint extent, output longint lo,
                                     output longint hi, output longint frac);
        longint pos;
        longint i0;
        longint i1;
        longint f;
        pos = (2 * d + 1) * scale - 65536;
        i0 = (pos < 0) ? -1 : pos / ONE_Q17;
        i1 = i0 + 1;
        if (i0 < 0) i0 = 0;
        if (i0 > extent - 1) i0 = extent - 1;
        if (i1 < 0) i1 = 0;
        if (i1 > extent - 1) i1 = extent - 1;
        f = pos - i0 * ONE_Q17;
        if (f < 0) f = 0;
        if (f > ONE_Q17) f = ONE_Q17;
        lo = i0;
        hi = i1;
        frac = f / 2;
    endfunction

    // Bilinear blend in Q.32 against the threshold scaled by 2^32.
    function automatic logic [M_TDATA_W-1:0] predict_mask(input logic [11:0] dx,
                                                          input logic [11:0] dy);
        longint w, h, d_x, d_y;
        longint x0, x1, y0, y1;
        longint fx, fy, gx, gy;
        longint blend, limit;
        w = extent_of(width_reg, SRC_MAX_W_DEF);
        h = extent_of(height_reg, SRC_MAX_H_DEF);
        d_x = dx;
        d_y = dy;
        if (d_x > DST_MAX_DEF - 1) d_x = DST_MAX_DEF - 1;
        if (d_y > DST_MAX_DEF - 1) d_y = DST_MAX_DEF - 1;
        map_axis(d_x, scale_x_reg, w, x0, x1, fx);
        map_axis(d_y, scale_y_reg, h, y0, y1, fy);
        gx = 65536 - fx;
        gy = 65536 - fy;
        blend = logit_at(y0 * w + x0) * (gx * gy)
              + logit_at(y0 * w + x1) * (fx * gy)
              + logit_at(y1 * w + x0) * (gx * fy)
              + logit_at(y1 * w + x1) * (fx * fy);
        limit = longint'(thr_reg) * 64'sd4294967296;
        return (blend > limit) ? MASK_ON : MASK_OFF;
    endfunction

    function automatic void note_mismatch(input string what, input int exp_val,
                                          input int act_val);
        mismatches++;
        if (mismatches <= 10)
            $display("%s: expected %0d, got %0d at %0t", what, exp_val, act_val, $realtime);
    endfunction

    // Results are checked before new words are predicted, so a word can never
    // match a prediction made at the same edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            width_reg = 8'd1;
            height_reg = 8'd1;
            scale_x_reg = 24'd65536;
            scale_y_reg = 24'd65536;
            thr_reg = '0;
            mask_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (mask_q.size() == 0) begin
                    note_mismatch("result word with no pixel pending", -1, m_tdata);
                end else begin
                    want = mask_q.pop_front();
                    if (m_tdata !== want) note_mismatch("mask_byte", want, m_tdata);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SOURCE_WIDTH:  width_reg = cfg_data[7:0];
                    REG_SOURCE_HEIGHT: height_reg = cfg_data[7:0];
                    REG_SCALE_X:       scale_x_reg = cfg_data;
                    REG_SCALE_Y:       scale_y_reg = cfg_data;
                    REG_THRESHOLD:     thr_reg = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == OP_LOAD)
                    logit_mem[s_tdata[13:0]] = s_tdata[29:14];
                else
                    mask_q.insert(mask_q.size(),
                                  predict_mask(s_tdata[41:30], s_tdata[53:42]));
            end
        end
        outstanding <= mask_q.size();
    end

endmodule

@@ test/tb_bilinear_mask_upsample_threshold_unit.sv @@
`timescale 1ns / 1ps

module tb_bilinear_mask_upsample_threshold_unit;

    import bmut_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int WORD_TARGET = 1550;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [0:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int mismatches;
    int outstanding;
    int words_sent = 0;
    int loaded_upto = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    bit tx_choppy = 1'b0;
    bit rx_choppy = 1'b0;

    bilinear_mask_upsample_threshold_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bmut_mask_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Gap length between words: mostly none, some short, a few long.
    function automatic int idle_len(input bit choppy);
        int r;
        r = $urandom_range(0, 99);
        if (!choppy || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int extent_of(input logic [7:0] v);
        if (v == 0) return 1;
        return (v > SRC_MAX_W_DEF) ? SRC_MAX_W_DEF : v;
    endfunction

    // Logits mostly near zero, some anywhere, a few at the extremes.
    function automatic logic [15:0] pick_logit();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 16'($urandom_range(0, 2047) - 1024);
        if (r < 85) return 16'($urandom());
        case ($urandom_range(0, 3))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'hffff;
            default: return 16'h0000;
        endcase
    endfunction

    // Destination coordinates mostly inside the destination image, some anywhere.
    function automatic logic [11:0] pick_dest(input int span);
        if ($urandom_range(0, 99) < 75)
            return 12'((span + 1 > 4095) ? $urandom_range(0, 4095) : $urandom_range(0, span + 1));
        return 12'($urandom());
    endfunction

    function automatic void pick_scale(input int ext, output logic [23:0] scale,
                                       output int span);
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            span = $urandom_range(1, 96);
            scale = 24'((ext << 16) / span);
        end else if (r < 75) begin
            span = 8;
            case ($urandom_range(0, 3))
                0: scale = 24'd0;
                1: scale = 24'hffffff;
                2: scale = 24'h800000;
                default: scale = 24'h010000;
            endcase
        end else begin
            span = $urandom_range(1, 64);
            scale = 24'($urandom_range(0, 24'h800000) >> $urandom_range(0, 7));
        end
    endfunction

    // Receiver side: random stalls while choppy, always ready otherwise.
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            stall_left <= idle_len(rx_choppy);
        end
    end

    // Watchdog on cycles in which no word moves on any channel.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic push_word(input logic op, input logic [S_TDATA_W-1:0] data);
        int gap;
        s_tuser <= op;
        s_tdata <= data;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        words_sent++;
        gap = idle_len(tx_choppy);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Unused fields of each word carry random bits; the top two bits are zero.
    task automatic send_load(input logic [13:0] idx, input logic [15:0] logit);
        push_word(OP_LOAD, {2'b00, 24'($urandom()), logit, idx});
    endtask

    task automatic send_pixel(input logic [11:0] dx, input logic [11:0] dy);
        push_word(OP_PIXEL, {2'b00, dy, dx, 30'($urandom())});
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // Wait until every pixel has its result, then let trailing loads finish.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    // One setting of the registers: load every sample it can read, then pixels
    // with a sprinkling of loads in between.
    task automatic run_phase(input logic [7:0] wreg, input logic [7:0] hreg,
                             input logic [23:0] sx, input logic [23:0] sy,
                             input logic [15:0] thr, input int span_x,
                             input int span_y, input int pixels);
        int w;
        int h;
        int needed;
        settle();
        cfg_write(REG_SOURCE_WIDTH, {16'b0, wreg});
        cfg_write(REG_SOURCE_HEIGHT, {16'b0, hreg});
        cfg_write(REG_SCALE_X, sx);
        cfg_write(REG_SCALE_Y, sy);
        cfg_write(REG_THRESHOLD, {8'b0, thr});
        cfg_valid <= 1'b0;
        tx_choppy = ($urandom_range(0, 2) != 0);
        rx_choppy = ($urandom_range(0, 2) != 0);
        w = extent_of(wreg);
        h = extent_of(hreg);
        needed = ((sy == 0) ? 0 : (h - 1) * w) + ((sx == 0) ? 1 : w);
        for (int i = loaded_upto; i < needed; i++) send_load(14'(i), pick_logit());
        if (needed > loaded_upto) loaded_upto = needed;
        repeat (pixels) begin
            if ($urandom_range(0, 99) < 20) begin
                if ($urandom_range(0, 1) == 0)
                    send_load(14'($urandom_range(0, loaded_upto - 1)), pick_logit());
                else
                    send_load(14'($urandom()), pick_logit());
            end
            send_pixel(pick_dest(span_x), pick_dest(span_y));
        end
    endtask

    initial begin
        logic [7:0]  wreg;
        logic [7:0]  hreg;
        logic [23:0] sx;
        logic [23:0] sy;
        logic [15:0] thr;
        int          span_x;
        int          span_y;
        int          r;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: one sample, unit scales, threshold zero.
        send_load(14'd0, 16'h7fff);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'hfff, 12'hfff);
        send_load(14'd0, 16'h8000);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd1, 12'hfff);
        send_load(14'd0, 16'h0000);
        send_pixel(12'd7, 12'd3);
        send_load(14'd0, 16'h0001);
        send_pixel(12'd0, 12'd0);
        send_load(14'h3fff, 16'h5a5a);
        send_pixel(12'd0, 12'd0);
        loaded_upto = 1;

        // Zero sizes and zero scales; widest source on one row; oversize width at
        // the largest scale; oversize height.
        run_phase(8'd0, 8'd0, 24'd0, 24'd0, 16'h8000, 63, 63, 20);
        run_phase(8'd128, 8'd128, 24'h008000, 24'd0, 16'h7fff, 256, 63, 30);
        run_phase(8'd255, 8'd3, 24'hffffff, 24'h800000, 16'h0100, 4, 4, 30);
        run_phase(8'd2, 8'd255, 24'h010000, 24'h020000, 16'h0000, 2, 64, 40);

        // Random settings, mostly small sources with realistic scales.
        while (words_sent < WORD_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                wreg = 8'($urandom_range(0, 255));
                hreg = 8'($urandom_range(0, 4));
            end else if (r < 20) begin
                wreg = 8'($urandom_range(1, 4));
                hreg = 8'($urandom_range(0, 255));
            end else begin
                wreg = 8'($urandom_range(1, 32));
                hreg = 8'($urandom_range(1, 24));
            end
            pick_scale(extent_of(wreg), sx, span_x);
            pick_scale(extent_of(hreg), sy, span_y);
            r = $urandom_range(0, 99);
            if (r < 50) thr = 16'($urandom_range(0, 2047) - 1024);
            else if (r < 80) thr = 16'($urandom());
            else thr = 16'h0000;
            run_phase(wreg, hreg, sx, sy, thr, span_x, span_y, $urandom_range(20, 100));
        end

        settle();
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/bmut_pkg.sv
rtl/bmut_axis.sv
rtl/bmut_store.sv
rtl/bilinear_mask_upsample_threshold_unit.sv
test/bmut_mask_checker.sv
test/tb_bilinear_mask_upsample_threshold_unit.sv
